// File: rtl/core/fbgm_pkg.sv
// ---------------------------------------------------------------------------
// fbgm_pkg: shared types and constants
// Action codes, layer geometry and the structs that travel between the
// counter block and the pixel pipeline of the background mixer.
// ---------------------------------------------------------------------------
package fbgm_pkg;

  // Layer geometry: four layers of 256 rows by 32 bytes each.
  localparam int LAYERS      = 4;
  localparam int LAYER_BYTES = 8192;
  localparam int LAYER_AW    = $clog2(LAYER_BYTES);
  localparam int LATCHES     = 16;

  // Depth of the result queue in front of the output channel.
  localparam int OUTQ_DEPTH  = 4;
  localparam int OUTQ_PW     = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW     = $clog2(OUTQ_DEPTH + 1);

  // Input action codes.
  localparam logic [2:0] ACT_LOAD_GFX   = 3'd0;
  localparam logic [2:0] ACT_LOAD_MIXER = 3'd1;
  localparam logic [2:0] ACT_WRITE_LATCH = 3'd2;
  localparam logic [2:0] ACT_BEGIN_LINE = 3'd3;
  localparam logic [2:0] ACT_PIXEL      = 3'd4;

  // Configuration register byte addresses.
  localparam logic [0:0] REG_FLIP_MODE  = 1'b0;

  // Pixel request issued along with the graphics reads.
  typedef struct packed {
    logic                    valid;
    logic [LAYERS-1:0]       live;     // layer enabled and column in range
    logic [LAYERS-1:0][1:0]  sub;      // pixel position inside the byte
    logic [3:0]              mix_sel;
    logic [3:0]              bank;
  } pix_req_t;

  // Mixer store write request.
  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    logic [1:0] data;
  } mix_wr_t;

endpackage

// File: rtl/core/fbgm_in_if.sv
// ---------------------------------------------------------------------------
// fbgm_in_if: input item channel
// Valid/ready channel that carries one action item per transfer.
// ---------------------------------------------------------------------------
interface fbgm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [14:0] gfx_address;
  logic [7:0]  mixer_index;
  logic [3:0]  latch_index;
  logic [7:0]  data;

  modport source (
    output valid, action, gfx_address, mixer_index, latch_index, data,
    input  ready
  );

  modport sink (
    input  valid, action, gfx_address, mixer_index, latch_index, data,
    output ready
  );
endinterface

// File: rtl/core/fbgm_out_if.sv
// ---------------------------------------------------------------------------
// fbgm_out_if: result channel
// Valid/ready channel that carries one pixel color per transfer.
// ---------------------------------------------------------------------------
interface fbgm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] color_index;
  logic [3:0] palette_bank;

  modport source (
    output valid, color_index, palette_bank,
    input  ready
  );

  modport sink (
    input  valid, color_index, palette_bank,
    output ready
  );
endinterface

// File: rtl/core/fbgm_gfx_bank.sv
// ---------------------------------------------------------------------------
// fbgm_gfx_bank: graphics memory of one layer
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
module fbgm_gfx_bank
  import fbgm_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [LAYER_AW-1:0] waddr,
  input  logic [7:0]          wdata,
  input  logic                re,
  input  logic [LAYER_AW-1:0] raddr,
  output logic [7:0]          rdata
);

  logic [7:0] mem [LAYER_BYTES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/fbgm_ctrl.sv
// ---------------------------------------------------------------------------
// fbgm_ctrl: latch file, line registers and per-layer counters
// Decodes each accepted item, issues the graphics reads of a pixel and
// steps the scroll and window counters after it.
// ---------------------------------------------------------------------------
module fbgm_ctrl
  import fbgm_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              flip_mode,
  input  logic                              xfer,
  input  logic [2:0]                        action,
  input  logic [14:0]                       gfx_address,
  input  logic [7:0]                        mixer_index,
  input  logic [3:0]                        latch_index,
  input  logic [7:0]                        data,
  output logic [LAYERS-1:0]                 gfx_we,
  output logic [LAYER_AW-1:0]               gfx_waddr,
  output logic [7:0]                        gfx_wdata,
  output logic                              gfx_re,
  output logic [LAYERS-1:0][LAYER_AW-1:0]   gfx_raddr,
  output pix_req_t                          req_r,
  output mix_wr_t                           mix_wr
);

  logic [LATCHES-1:0][7:0] latch_r, latch_nxt;
  logic [LAYERS-1:0][7:0]  scroll_r, scroll_nxt;
  logic [LAYERS-1:0][7:0]  row_r, row_nxt;
  logic [LAYERS-1:0][4:0]  wstart_r, wstart_nxt;
  logic [LAYERS-1:0][4:0]  wstop_r, wstop_nxt;
  logic [3:0]              mix_sel_r, mix_sel_nxt;
  logic [3:0]              bank_r, bank_nxt;
  pix_req_t                req_nxt;
  logic                    is_pixel;

  assign is_pixel = xfer && (action == ACT_PIXEL);

  // Memory write decode.
  always_comb begin
    gfx_we = '0;
    if (xfer && (action == ACT_LOAD_GFX)) begin
      gfx_we[gfx_address[14:LAYER_AW]] = 1'b1;
    end
  end
  assign gfx_waddr   = gfx_address[LAYER_AW-1:0];
  assign gfx_wdata   = data;
  assign mix_wr.en   = xfer && (action == ACT_LOAD_MIXER);
  assign mix_wr.idx  = mixer_index;
  assign mix_wr.data = data[1:0];

  // Graphics reads of a pixel: row times 32 plus column over four.
  assign gfx_re = is_pixel;
  always_comb begin
    for (int i = 0; i < LAYERS; i++) begin
      gfx_raddr[i] = {row_r[i], scroll_r[i][6:2]};
    end
  end

  // Pixel request that follows the graphics data into the pipeline.
  always_comb begin
    req_nxt.valid   = is_pixel;
    req_nxt.mix_sel = mix_sel_r;
    req_nxt.bank    = bank_r;
    for (int i = 0; i < LAYERS; i++) begin
      req_nxt.live[i] = (wstart_r[i][4] ^ wstop_r[i][4]) && !scroll_r[i][7];
      req_nxt.sub[i]  = scroll_r[i][1:0];
    end
  end

  // Latch writes, line start copies and counter steps.
  always_comb begin
    logic [7:0] s_up;
    logic       wrap;
    latch_nxt   = latch_r;
    scroll_nxt  = scroll_r;
    row_nxt     = row_r;
    wstart_nxt  = wstart_r;
    wstop_nxt   = wstop_r;
    mix_sel_nxt = mix_sel_r;
    bank_nxt    = bank_r;
    s_up        = '0;
    wrap        = 1'b0;
    if (xfer) begin
      unique case (action)
        ACT_WRITE_LATCH: begin
          latch_nxt[latch_index] = data;
        end
        ACT_BEGIN_LINE: begin
          for (int i = 0; i < LAYERS; i++) begin
            scroll_nxt[i] = latch_r[2*i];
            row_nxt[i]    = latch_r[2*i+1];
            wstart_nxt[i] = {1'b0, latch_r[8+i][3:0]};
            wstop_nxt[i]  = {1'b0, latch_r[8+i][7:4]};
          end
          mix_sel_nxt = latch_r[12][3:0];
          bank_nxt    = latch_r[12][7:4];
        end
        ACT_PIXEL: begin
          for (int i = 0; i < LAYERS; i++) begin
            s_up = scroll_r[i] + 8'd1;
            if (flip_mode) begin
              wrap          = (scroll_r[i][4:0] == 5'd0);
              scroll_nxt[i] = scroll_r[i] - 8'd1;
            end else begin
              wrap          = (s_up[4:0] == 5'd0);
              scroll_nxt[i] = s_up;
            end
            if (wrap) begin
              wstart_nxt[i] = wstart_r[i] + 5'd1;
              wstop_nxt[i]  = wstop_r[i] + 5'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r   <= '0;
      scroll_r  <= '0;
      row_r     <= '0;
      wstart_r  <= '0;
      wstop_r   <= '0;
      mix_sel_r <= '0;
      bank_r    <= '0;
      req_r     <= '0;
    end else begin
      latch_r   <= latch_nxt;
      scroll_r  <= scroll_nxt;
      row_r     <= row_nxt;
      wstart_r  <= wstart_nxt;
      wstop_r   <= wstop_nxt;
      mix_sel_r <= mix_sel_nxt;
      bank_r    <= bank_nxt;
      req_r     <= req_nxt;
    end
  end

endmodule

// File: rtl/core/fbgm_pix_pipe.sv
// ---------------------------------------------------------------------------
// fbgm_pix_pipe: layer combine, mixer lookup and result queue
// Forms the layer pixels from the graphics data, reads the mixer store
// and queues the resulting colors for the output channel.
// ---------------------------------------------------------------------------
module fbgm_pix_pipe
  import fbgm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  pix_req_t                 req,
  input  logic [LAYERS-1:0][7:0]   gfx_rdata,
  input  mix_wr_t                  mix_wr,
  output logic [OUTQ_CW:0]         busy,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0]               out_color,
  output logic [3:0]               out_bank
);

  logic [1:0] mix_mem [256];

  logic [LAYERS-1:0][1:0] pix;
  logic [LAYERS-1:0]      mask;

  logic                   v2_r;
  logic [LAYERS-1:0][1:0] pix2_r;
  logic [3:0]             bank2_r;
  logic [1:0]             sel_r;
  logic [3:0]             color;

  logic [OUTQ_DEPTH-1:0][7:0] q_r;
  logic [OUTQ_PW-1:0]         wptr_r, rptr_r;
  logic [OUTQ_CW-1:0]         cnt_r, cnt_nxt;
  logic                       q_push, q_pop;

  // Layer pixels: bit 4+sub of the byte is the high bit, bit sub the low.
  always_comb begin
    for (int i = 0; i < LAYERS; i++) begin
      if (req.live[i]) begin
        pix[i] = {gfx_rdata[i][4 + req.sub[i]], gfx_rdata[i][req.sub[i]]};
      end else begin
        pix[i] = 2'b00;
      end
      mask[i] = (pix[i] != 2'b00);
    end
  end

  // Mixer store write port.
  always_ff @(posedge clk) begin
    if (mix_wr.en) begin
      mix_mem[mix_wr.idx] <= mix_wr.data;
    end
  end

  // Mixer read; the layer pixels and bank travel alongside.
  always_ff @(posedge clk) begin
    if (req.valid) begin
      sel_r   <= mix_mem[{req.mix_sel, mask}];
      pix2_r  <= pix;
      bank2_r <= req.bank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= req.valid;
    end
  end

  // Selected layer times four plus its pixel.
  assign color = {sel_r, pix2_r[sel_r]};

  // Result queue.
  assign q_push    = v2_r;
  assign q_pop     = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_color = q_r[rptr_r][3:0];
  assign out_bank  = q_r[rptr_r][7:4];

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (q_pop && !q_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_r[wptr_r] <= {bank2_r, color};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (q_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (q_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Queue entries plus pixels still in flight.
  assign busy = {1'b0, cnt_r} + {{OUTQ_CW{1'b0}}, req.valid}
              + {{OUTQ_CW{1'b0}}, v2_r};

endmodule

// File: rtl/core/four_layer_background_mixer_unit.sv
// ---------------------------------------------------------------------------
// four_layer_background_mixer_unit: four-layer background pixel generator
// Pipeline: a pixel transfer passes the graphics read, the mixer read and
//   the result queue, in that order, before its color is offered.
// Throughput: one item per cycle while the result queue has room, set by one
//   read per graphics bank and one mixer read; a four-entry queue absorbs stalls.
// Reset: synchronous; clears latches, counters and the queue.
//   Graphics and mixer memories are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module four_layer_background_mixer_unit
  import fbgm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fbgm_in_if.sink     in_ch,
  fbgm_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                             flip_mode_r;
  logic                             in_xfer;
  logic [OUTQ_CW:0]                 busy;
  logic [LAYERS-1:0]                gfx_we;
  logic [LAYER_AW-1:0]              gfx_waddr;
  logic [7:0]                       gfx_wdata;
  logic                             gfx_re;
  logic [LAYERS-1:0][LAYER_AW-1:0]  gfx_raddr;
  logic [LAYERS-1:0][7:0]           gfx_rdata;
  pix_req_t                         req;
  mix_wr_t                          mix_wr;

  // Configuration port: single flip mode register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_FLIP_MODE) ? {31'd0, flip_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr == REG_FLIP_MODE)) begin
      flip_mode_r <= cfg_pwdata[0];
    end
  end

  // Items are taken while the result queue has room for every pixel in flight.
  assign in_ch.ready = (busy < OUTQ_DEPTH);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  fbgm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .flip_mode   (flip_mode_r),
    .xfer        (in_xfer),
    .action      (in_ch.action),
    .gfx_address (in_ch.gfx_address),
    .mixer_index (in_ch.mixer_index),
    .latch_index (in_ch.latch_index),
    .data        (in_ch.data),
    .gfx_we      (gfx_we),
    .gfx_waddr   (gfx_waddr),
    .gfx_wdata   (gfx_wdata),
    .gfx_re      (gfx_re),
    .gfx_raddr   (gfx_raddr),
    .req_r       (req),
    .mix_wr      (mix_wr)
  );

  // One graphics bank per layer so all layers are read in the same cycle.
  for (genvar g = 0; g < LAYERS; g++) begin : g_bank
    fbgm_gfx_bank u_bank (
      .clk   (clk),
      .we    (gfx_we[g]),
      .waddr (gfx_waddr),
      .wdata (gfx_wdata),
      .re    (gfx_re),
      .raddr (gfx_raddr[g]),
      .rdata (gfx_rdata[g])
    );
  end

  fbgm_pix_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .gfx_rdata (gfx_rdata),
    .mix_wr    (mix_wr),
    .busy      (busy),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_color (out_ch.color_index),
    .out_bank  (out_ch.palette_bank)
  );

endmodule

// File: tb/fbgm_tb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fbgm_tb_pkg: transfer type and pixel scoreboard for the background mixer
// Keeps its own copy of the mixer state, advances it with every accepted
// input transfer and queues the pixel color that each pixel transfer yields.
// ---------------------------------------------------------------------------
package fbgm_tb_pkg;
  import fbgm_pkg::*;

  localparam int GFX_BYTES = LAYERS * LAYER_BYTES;

  // Action codes that the block ignores.
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  // Latches with a fixed role; latches 0..7 hold scroll and row per layer.
  localparam int LATCH_WINDOW0 = 8;
  localparam int LATCH_MIXER   = 12;

  typedef struct packed {
    logic [2:0]  action;
    logic [14:0] gfx_address;
    logic [7:0]  mixer_index;
    logic [3:0]  latch_index;
    logic [7:0]  data;
  } bg_item_t;

  typedef struct packed {
    logic [3:0] color_index;
    logic [3:0] palette_bank;
  } bg_pixel_t;

  class bg_pixel_scoreboard;
    bit          flip;
    bit [7:0]    latches [LATCHES];
    bit [7:0]    scroll [LAYERS];
    bit [7:0]    row [LAYERS];
    bit [4:0]    win_start [LAYERS];
    bit [4:0]    win_stop [LAYERS];
    bit [3:0]    mix_sel;
    bit [3:0]    bank;
    bit [7:0]    gfx_mem [GFX_BYTES];
    bit          gfx_written [GFX_BYTES];
    bit [1:0]    mix_mem [256];
    bit          mix_written [256];
    bg_pixel_t   pending_pixels [$];
    int unsigned pixels_checked;
    int unsigned mismatches;

    // A layer reads graphics only with its window open and its column below 128.
    function bit layer_live(int i);
      return (win_start[i][4] ^ win_stop[i][4]) && !scroll[i][7];
    endfunction

    function bit [14:0] layer_addr(int i);
      return {2'(i), row[i], scroll[i][6:2]};
    endfunction

    // The two pixel bits sit at sub and sub + 4 of the graphics byte.
    function bit [1:0] layer_pixel(int i);
      bit [7:0] b;
      bit [1:0] sub;
      if (!layer_live(i)) return 2'd0;
      b = gfx_mem[layer_addr(i)];
      sub = scroll[i][1:0];
      return {b[4 + sub], b[sub]};
    endfunction

    function bit [7:0] mixer_slot();
      bit [3:0] mask;
      for (int i = 0; i < LAYERS; i++) mask[i] = (layer_pixel(i) != 2'd0);
      return {mix_sel, mask};
    endfunction

    function bg_pixel_t predict_pixel();
      bg_pixel_t px;
      bit [1:0]  layer;
      layer = mix_mem[mixer_slot()];
      px.color_index = {layer, layer_pixel(layer)};
      px.palette_bank = bank;
      return px;
    endfunction

    // Scroll counters step after each pixel; crossing a 32-column boundary
    // moves both window counters.
    function void step_scrolls();
      for (int i = 0; i < LAYERS; i++) begin
        if (!flip) scroll[i] = scroll[i] + 8'd1;
        if (scroll[i][4:0] == 5'd0) begin
          win_start[i]++;
          win_stop[i]++;
        end
        if (flip) scroll[i] = scroll[i] - 8'd1;
      end
    endfunction

    // Advance the state with one accepted input transfer.
    function void accept_item(bg_item_t it);
      case (it.action)
        ACT_LOAD_GFX: begin
          gfx_mem[it.gfx_address] = it.data;
          gfx_written[it.gfx_address] = 1'b1;
        end
        ACT_LOAD_MIXER: begin
          mix_mem[it.mixer_index] = it.data[1:0];
          mix_written[it.mixer_index] = 1'b1;
        end
        ACT_WRITE_LATCH: latches[it.latch_index] = it.data;
        ACT_BEGIN_LINE: begin
          for (int i = 0; i < LAYERS; i++) begin
            scroll[i] = latches[2 * i];
            row[i] = latches[2 * i + 1];
            win_start[i] = {1'b0, latches[LATCH_WINDOW0 + i][3:0]};
            win_stop[i] = {1'b0, latches[LATCH_WINDOW0 + i][7:4]};
          end
          mix_sel = latches[LATCH_MIXER][3:0];
          bank = latches[LATCH_MIXER][7:4];
        end
        ACT_PIXEL: begin
          pending_pixels.push_back(predict_pixel());
          step_scrolls();
        end
        default: ;
      endcase
    endfunction

    // Compare one result transfer with the oldest predicted pixel.
    function void check_pixel(logic [3:0] color, logic [3:0] pbank);
      bg_pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: color_index %0d, palette_bank %0d", color, pbank);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (color !== want.color_index) begin
        $error("color_index mismatch: expected %0d, actual %0d", want.color_index, color);
        mismatches++;
      end
      if (pbank !== want.palette_bank) begin
        $error("palette_bank mismatch: expected %0d, actual %0d", want.palette_bank, pbank);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// File: tb/tb_four_layer_background_mixer_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_four_layer_background_mixer_unit: regression for the background mixer
// Sends load, latch, begin-line and pixel transfers with random gaps and
// random back-pressure, predicts every pixel color in a scoreboard and
// checks the result stream in order, across phases of both flip modes.
// ---------------------------------------------------------------------------
module tb_four_layer_background_mixer_unit;
  import fbgm_pkg::*;
  import fbgm_tb_pkg::*;

  localparam int RANDOM_ITEMS   = 1400;
  localparam int PHASES         = 8;
  localparam int DRAIN_SLACK    = 8;
  localparam int TAIL_CYCLES    = 12;
  localparam int LONG_HOLD      = 150;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [0:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  fbgm_in_if  in_ch ();
  fbgm_out_if out_ch ();

  bg_pixel_scoreboard sb;
  bit          calm;
  int unsigned hold_requests;
  int unsigned holds_done;
  int unsigned items_sent;
  int unsigned lines_started;
  int unsigned idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  four_layer_background_mixer_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Every accepted input transfer advances the scoreboard; every result is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.accept_item(bg_item_t'{in_ch.action, in_ch.gfx_address, in_ch.mixer_index,
                                  in_ch.latch_index, in_ch.data});
      if (out_ch.valid && out_ch.ready)
        sb.check_pixel(out_ch.color_index, out_ch.palette_bank);
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no transfer for %0d cycles, %0d results outstanding", idle_cycles,
             sb.pending_pixels.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly no gap, some short ones and a few long ones; none in calm phases.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: random stalls, and one long hold-off when asked for.
  initial begin : result_sink
    int unsigned stall_left;
    out_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  // Offer one transfer at a falling edge and hold it until it is accepted.
  task automatic send_item(bg_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= it.action;
    in_ch.gfx_address <= it.gfx_address;
    in_ch.mixer_index <= it.mixer_index;
    in_ch.latch_index <= it.latch_index;
    in_ch.data        <= it.data;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (it.action <= ACT_PIXEL) items_sent++;
    if (it.action == ACT_BEGIN_LINE) lines_started++;
  endtask

  // Fields that the action does not use carry random values.
  function automatic bg_item_t make_item(logic [2:0] action);
    bg_item_t it;
    it.action      = action;
    it.gfx_address = 15'($urandom);
    it.mixer_index = 8'($urandom);
    it.latch_index = 4'($urandom);
    it.data        = 8'($urandom);
    return it;
  endfunction

  task automatic send_action(logic [2:0] action);
    send_item(make_item(action));
  endtask

  task automatic send_gfx(logic [14:0] addr, logic [7:0] value);
    bg_item_t it;
    it = make_item(ACT_LOAD_GFX);
    it.gfx_address = addr;
    it.data = value;
    send_item(it);
  endtask

  task automatic send_mixer(logic [7:0] idx, logic [7:0] value);
    bg_item_t it;
    it = make_item(ACT_LOAD_MIXER);
    it.mixer_index = idx;
    it.data = value;
    send_item(it);
  endtask

  task automatic send_latch(logic [3:0] idx, logic [7:0] value);
    bg_item_t it;
    it = make_item(ACT_WRITE_LATCH);
    it.latch_index = idx;
    it.data = value;
    send_item(it);
  endtask

  // A pixel may only read graphics bytes and a mixer entry that hold data,
  // so any that were never loaded get a random value first.
  task automatic send_pixel();
    for (int i = 0; i < LAYERS; i++) begin
      if (sb.layer_live(i) && !sb.gfx_written[sb.layer_addr(i)])
        send_gfx(sb.layer_addr(i), 8'($urandom));
    end
    if (!sb.mix_written[sb.mixer_slot()]) send_mixer(sb.mixer_slot(), 8'($urandom));
    send_action(ACT_PIXEL);
  endtask

  // Stray transfers in the middle of a line.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_gfx(15'($urandom), 8'($urandom));
      1: send_mixer(8'($urandom), 8'($urandom));
      2: send_latch(4'($urandom), 8'($urandom));
      default: send_action(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)));
    endcase
  endtask

  // Scroll values mostly start just before a window carry, mostly on screen.
  function automatic logic [7:0] pick_scroll();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(0, 9) < 6)
      v[4:0] = sb.flip ? 5'($urandom_range(0, 3)) : 5'($urandom_range(28, 31));
    if ($urandom_range(0, 9) < 8) v[7] = 1'b0;
    return v;
  endfunction

  // Window start high and stop below it, so the window opens within a few carries.
  function automatic logic [7:0] pick_window();
    logic [3:0] start_n;
    logic [3:0] stop_n;
    if ($urandom_range(0, 9) < 2) return 8'($urandom);
    start_n = 4'($urandom_range(13, 15));
    stop_n  = 4'($urandom_range(0, start_n - 1));
    return {stop_n, start_n};
  endfunction

  // One scanline: some latch writes, a begin-line and a run of pixels.
  task automatic run_line(int npix);
    logic [3:0] idx;
    logic [7:0] value;
    repeat ($urandom_range(2, 10)) begin
      idx = 4'($urandom);
      if (idx < LATCH_WINDOW0 && !idx[0]) value = pick_scroll();
      else if (idx >= LATCH_WINDOW0 && idx < LATCH_MIXER) value = pick_window();
      else value = 8'($urandom);
      send_latch(idx, value);
    end
    send_action(ACT_BEGIN_LINE);
    repeat (npix) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      send_pixel();
    end
  endtask

  // One APB access: setup cycle, then access cycle until pready.
  task automatic cfg_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= REG_FLIP_MODE;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write flip_mode and read it back.
  task automatic set_flip(logic [31:0] value);
    logic [31:0] rdata;
    cfg_access(1'b1, value, rdata);
    sb.flip = value[0];
    cfg_access(1'b0, 32'($urandom), rdata);
    if (rdata !== 32'(sb.flip)) begin
      $error("flip_mode mismatch: expected %0d, actual %0d", sb.flip, rdata);
      sb.mismatches++;
    end
  endtask

  // Stop sending and wait until every predicted pixel has come out.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    sb = new();
    rst_n             = 1'b0;
    calm              = 1'b0;
    hold_requests     = 0;
    items_sent        = 0;
    lines_started     = 0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_LOAD_GFX;
    in_ch.gfx_address = '0;
    in_ch.mixer_index = '0;
    in_ch.latch_index = '0;
    in_ch.data        = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = REG_FLIP_MODE;
    cfg_pwdata        = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: field extremes, ignored actions, a window that opens
    // on the first carry, and a layer that scrolls past column 127.
    set_flip(32'h0);
    send_gfx(15'h7fff, 8'hff);
    send_gfx(15'h0000, 8'h00);
    send_mixer(8'hff, 8'hff);
    send_latch(4'hf, 8'hff);
    send_latch(4'h0, 8'h1f);
    send_latch(4'h1, 8'h00);
    send_latch(4'(LATCH_WINDOW0), 8'h0f);
    send_latch(4'(LATCH_MIXER), 8'ha3);
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) send_action(3'(a));
    send_action(ACT_BEGIN_LINE);
    repeat (4) send_pixel();
    send_latch(4'h2, 8'h7f);
    send_latch(4'(LATCH_WINDOW0 + 1), 8'h0f);
    send_action(ACT_BEGIN_LINE);
    repeat (3) send_pixel();
    wait_idle();

    // Random phases, alternating flip mode with junk in the unused bits.
    for (int p = 0; p < PHASES; p++) begin
      set_flip({31'($urandom), p % 2 == 0});
      calm = (p == 3);
      if (p == 2) hold_requests++;
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) run_line($urandom_range(8, 70));
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d input items over %0d scanlines in %0d flip-mode phases,",
             items_sent, lines_started, PHASES);
    $display("with %0d pixel colors checked and %0d mismatches.", sb.pixels_checked,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: four_layer_background_mixer_unit.f
rtl/core/fbgm_pkg.sv
rtl/core/fbgm_in_if.sv
rtl/core/fbgm_out_if.sv
rtl/core/fbgm_gfx_bank.sv
rtl/core/fbgm_ctrl.sv
rtl/core/fbgm_pix_pipe.sv
rtl/core/four_layer_background_mixer_unit.sv
tb/fbgm_tb_pkg.sv
tb/tb_four_layer_background_mixer_unit.sv
